>>> src/channel_affinity_dispatcher_core_macros.svh
// Assertion helpers for the channel affinity dispatcher.
`ifndef CHANNEL_AFFINITY_DISPATCHER_CORE_MACROS_SVH
`define CHANNEL_AFFINITY_DISPATCHER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CAD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CAD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/cad_pkg.sv
package cad_pkg;

    localparam int MAX_WORKERS_DEF   = 16;
    localparam int CHANNEL_SLOTS_DEF = 64;
    localparam int CHAN_ID_W         = 64;
    localparam int TAG_W             = 32;
    localparam int WCOUNT_W          = 5;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_ROUTE  = 2'd2,
        REQ_UNUSED = 2'd3
    } cad_req_code_t;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_STOPPED = 3'd1,
        STS_UNKNOWN = 3'd2,
        STS_FULL    = 3'd3,
        STS_NOCMD   = 3'd4
    } cad_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_SCAN,
        ST_COMMIT
    } cad_state_t;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [CHAN_ID_W-1:0] channel_id;
        logic [TAG_W-1:0]     command_tag;
        logic                 command_present;
    } cad_req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [3:0]       worker;
        logic [TAG_W-1:0] routed_tag;
    } cad_rsp_t;

    // Update controls for one channel slot cell.
    typedef struct packed {
        logic clear;
        logic write;
        logic invalidate;
    } cad_slot_op_t;

    // Update controls for the worker load cells.
    typedef struct packed {
        logic clear;
        logic inc_en;
        logic dec_en;
    } cad_load_op_t;

endpackage

>>> src/cad_slot_cell.sv
module cad_slot_cell #(
    parameter int WIDX_W = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cad_pkg::cad_slot_op_t          op,
    input  logic [cad_pkg::CHAN_ID_W-1:0]  req_id,
    input  logic [WIDX_W-1:0]              wr_worker,
    output logic                           valid,
    output logic                           hit,
    output logic [WIDX_W-1:0]              worker
);
    import cad_pkg::*;

    logic                 valid_reg;
    logic [CHAN_ID_W-1:0] channel_reg;
    logic [WIDX_W-1:0]    worker_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (op.clear) begin
            valid_reg <= 1'b0;
        end else if (op.write) begin
            valid_reg <= 1'b1;
        end else if (op.invalidate) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (op.write) begin
            channel_reg <= req_id;
            worker_reg  <= wr_worker;
        end
    end

    assign valid  = valid_reg;
    assign hit    = valid_reg && (channel_reg == req_id);
    assign worker = worker_reg;

endmodule

>>> src/cad_load_cell.sv
module cad_load_cell #(
    parameter int IDX    = 0,
    parameter int WIDX_W = 4,
    parameter int LOAD_W = 7,
    parameter int NCNT_W = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cad_pkg::cad_load_op_t op,
    input  logic [WIDX_W-1:0]     inc_idx,
    input  logic [WIDX_W-1:0]     dec_idx,
    input  logic [NCNT_W-1:0]     active_count,
    input  logic [LOAD_W-1:0]     best_load_in,
    input  logic [WIDX_W-1:0]     best_idx_in,
    input  logic                  best_vld_in,
    output logic [LOAD_W-1:0]     best_load_out,
    output logic [WIDX_W-1:0]     best_idx_out,
    output logic                  best_vld_out
);
    import cad_pkg::*;

    logic [LOAD_W-1:0] load_reg;
    logic [LOAD_W-1:0] best_load_reg;
    logic [WIDX_W-1:0] best_idx_reg;
    logic              best_vld_reg;
    logic              active;
    logic              take_own;

    assign active   = NCNT_W'(IDX) < active_count;
    // Strict less-than keeps the earlier worker on a tie.
    assign take_own = active && (!best_vld_in || (load_reg < best_load_in));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg <= '0;
        end else if (op.clear) begin
            load_reg <= '0;
        end else if (op.inc_en && (inc_idx == WIDX_W'(IDX))) begin
            load_reg <= load_reg + LOAD_W'(1);
        end else if (op.dec_en && (dec_idx == WIDX_W'(IDX)) && (load_reg != '0)) begin
            load_reg <= load_reg - LOAD_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_vld_reg <= 1'b0;
        end else begin
            best_vld_reg <= take_own || best_vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_own) begin
            best_load_reg <= load_reg;
            best_idx_reg  <= WIDX_W'(IDX);
        end else begin
            best_load_reg <= best_load_in;
            best_idx_reg  <= best_idx_in;
        end
    end

    assign best_load_out = best_load_reg;
    assign best_idx_out  = best_idx_reg;
    assign best_vld_out  = best_vld_reg;

endmodule

>>> src/channel_affinity_dispatcher_core.sv
// Channel affinity dispatcher: binds 64-bit channel ids to workers and keeps a
// per-worker load count. Each request (add, remove, route) is one input
// transaction and yields exactly one result transaction. The block works on
// one request at a time. A remove, a route, a rejected request or an add of an
// already bound channel goes from acceptance to the result being presented
// through accept, a parallel compare against every channel slot cell, commit
// and the output register. An add that creates a new binding also waits for
// the least-loaded search, which travels down the row of worker load cells
// one cell per cycle before the commit.
// A new request is accepted in the cycle after the previous one is committed
// into the output register, even while that result still waits to be taken.
// No new request is taken before the previous one is committed, and a commit
// waits while the output register holds a result that is not being taken.
// Writing worker_count clears every binding and every load; a count of zero
// stops the pool and counts above MAX_WORKERS act as MAX_WORKERS.
// Configuration must only be written while the block is idle.
module channel_affinity_dispatcher_core #(
    parameter int MAX_WORKERS   = cad_pkg::MAX_WORKERS_DEF,
    parameter int CHANNEL_SLOTS = cad_pkg::CHANNEL_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cad_pkg::WCOUNT_W-1:0]  cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  cad_pkg::cad_req_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output cad_pkg::cad_rsp_t             m_data
);
    import cad_pkg::*;

`include "channel_affinity_dispatcher_core_macros.svh"

    // Worker index width, load counter width and scan counter width all follow
    // from the parameters.
    localparam int WIDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int LOAD_W = $clog2(CHANNEL_SLOTS + 1);
    localparam int CNT_W  = $clog2(MAX_WORKERS + 1);
    localparam int NCNT_W = ($clog2(MAX_WORKERS + 1) > WCOUNT_W) ?
                            $clog2(MAX_WORKERS + 1) : WCOUNT_W;

    // Control state.
    cad_state_t           state_reg, state_next;
    logic [WCOUNT_W-1:0]  worker_count_reg;
    logic [CNT_W-1:0]     scan_cnt_reg;
    logic                 m_valid_reg;

    // Request and lookup results held for the commit step.
    cad_req_t             req_reg;
    logic [CHANNEL_SLOTS-1:0] hit_reg;
    logic [CHANNEL_SLOTS-1:0] grant_reg;
    logic                 found_reg;
    logic                 free_any_reg;
    logic [WIDX_W-1:0]    hit_worker_reg;
    cad_rsp_t             m_data_reg;

    // Handshake and sequencing strobes.
    logic                 in_fire;
    logic                 capture_lookup;
    logic                 commit_fire;
    logic                 need_scan;

    // Slot cell row.
    logic [CHANNEL_SLOTS-1:0] slot_valid;
    logic [CHANNEL_SLOTS-1:0] slot_hit;
    logic [WIDX_W-1:0]    slot_worker [CHANNEL_SLOTS];
    logic [CHANNEL_SLOTS-1:0] free_vec;
    logic [CHANNEL_SLOTS-1:0] grant_next;
    logic [WIDX_W-1:0]    hit_worker_next;

    // Load cell row and its search chain.
    logic [LOAD_W-1:0]    chain_load [MAX_WORKERS+1];
    logic [WIDX_W-1:0]    chain_idx  [MAX_WORKERS+1];
    logic                 chain_vld  [MAX_WORKERS+1];
    cad_load_op_t         load_op;

    // Active worker count after clamping.
    logic [NCNT_W-1:0]    count_ext;
    logic [NCNT_W-1:0]    active_count;
    logic                 pool_stopped;

    // Commit decisions.
    cad_rsp_t             rsp;
    logic [WIDX_W-1:0]    sel_worker;
    logic [WIDX_W+3:0]    sel_worker_wide;
    logic                 do_write;
    logic                 do_inval;
    logic                 do_inc;
    logic                 do_dec;

    assign count_ext    = NCNT_W'(worker_count_reg);
    assign active_count = (count_ext > NCNT_W'(MAX_WORKERS)) ? NCNT_W'(MAX_WORKERS) : count_ext;
    assign pool_stopped = (active_count == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            worker_count_reg <= '0;
        end else if (cfg_wr_en) begin
            worker_count_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Channel slot cells. Every cell compares its stored id against the
    // pending request in parallel; the commit step writes or invalidates
    // the one cell picked during the lookup.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CHANNEL_SLOTS; i++) begin : g_slot
        cad_slot_op_t slot_op;

        assign slot_op.clear      = cfg_wr_en;
        assign slot_op.write      = commit_fire && do_write && grant_reg[i];
        assign slot_op.invalidate = commit_fire && do_inval && hit_reg[i];

        cad_slot_cell #(
            .WIDX_W (WIDX_W)
        ) u_slot (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .op        (slot_op),
            .req_id    (req_reg.channel_id),
            .wr_worker (chain_idx[MAX_WORKERS]),
            .valid     (slot_valid[i]),
            .hit       (slot_hit[i]),
            .worker    (slot_worker[i])
        );
    end

    // The lowest free slot is isolated with a single carry chain.
    assign free_vec   = ~slot_valid;
    assign grant_next = free_vec & ((~free_vec) + CHANNEL_SLOTS'(1));

    // A channel is bound in at most one slot, so an OR of the gated worker
    // fields yields the bound worker.
    always_comb begin
        hit_worker_next = '0;
        for (int i = 0; i < CHANNEL_SLOTS; i++) begin
            hit_worker_next = hit_worker_next | ({WIDX_W{slot_hit[i]}} & slot_worker[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            req_reg <= s_data;
        end
        if (capture_lookup) begin
            hit_reg        <= slot_hit;
            grant_reg      <= grant_next;
            found_reg      <= |slot_hit;
            free_any_reg   <= |free_vec;
            hit_worker_reg <= hit_worker_next;
        end
    end

    // ------------------------------------------------------------------
    // Worker load cells. The running best (load, index) pair moves one cell
    // per cycle, so the last cell holds the least-loaded active worker once
    // the loads have been stable long enough for the pair to pass every cell.
    // ------------------------------------------------------------------
    assign chain_load[0] = '0;
    assign chain_idx[0]  = '0;
    assign chain_vld[0]  = 1'b0;

    assign load_op.clear  = cfg_wr_en;
    assign load_op.inc_en = commit_fire && do_inc;
    assign load_op.dec_en = commit_fire && do_dec;

    for (genvar w = 0; w < MAX_WORKERS; w++) begin : g_load
        cad_load_cell #(
            .IDX    (w),
            .WIDX_W (WIDX_W),
            .LOAD_W (LOAD_W),
            .NCNT_W (NCNT_W)
        ) u_load (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .op            (load_op),
            .inc_idx       (chain_idx[MAX_WORKERS]),
            .dec_idx       (hit_worker_reg),
            .active_count  (active_count),
            .best_load_in  (chain_load[w]),
            .best_idx_in   (chain_idx[w]),
            .best_vld_in   (chain_vld[w]),
            .best_load_out (chain_load[w+1]),
            .best_idx_out  (chain_idx[w+1]),
            .best_vld_out  (chain_vld[w+1])
        );
    end

    // Counts cycles since acceptance; loads do not change while a request is
    // in flight, so a full count means the search result is current.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg <= '0;
        end else if (in_fire) begin
            scan_cnt_reg <= '0;
        end else if (scan_cnt_reg != CNT_W'(MAX_WORKERS)) begin
            scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign need_scan = (cad_req_code_t'(req_reg.req_type) == REQ_ADD) && !pool_stopped &&
                       !(|slot_hit) && (|free_vec);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                state_next = need_scan ? ST_SCAN : ST_COMMIT;
            end
            ST_SCAN: begin
                if (scan_cnt_reg == CNT_W'(MAX_WORKERS)) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        capture_lookup = 1'b0;
        commit_fire    = 1'b0;
        unique case (state_reg)
            ST_IDLE:    s_ready = 1'b1;
            ST_COMPARE: capture_lookup = 1'b1;
            ST_SCAN:    ;
            ST_COMMIT:  commit_fire = !m_valid_reg || m_ready;
            default:    ;
        endcase
    end

    assign in_fire = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Request decode at commit. A route without a command is rejected before
    // the stopped check; the unused request code answers ok with zeros.
    // ------------------------------------------------------------------
    always_comb begin
        rsp        = '0;
        sel_worker = '0;
        do_write   = 1'b0;
        do_inval   = 1'b0;
        do_inc     = 1'b0;
        do_dec     = 1'b0;
        if (cad_req_code_t'(req_reg.req_type) == REQ_UNUSED) begin
            rsp.status = STS_OK;
        end else if ((cad_req_code_t'(req_reg.req_type) == REQ_ROUTE) &&
                     !req_reg.command_present) begin
            rsp.status = STS_NOCMD;
        end else if (pool_stopped) begin
            rsp.status = STS_STOPPED;
        end else if (cad_req_code_t'(req_reg.req_type) == REQ_ADD) begin
            if (found_reg) begin
                sel_worker = hit_worker_reg;
            end else if (!free_any_reg) begin
                rsp.status = STS_FULL;
            end else begin
                sel_worker = chain_idx[MAX_WORKERS];
                do_write   = 1'b1;
                do_inc     = 1'b1;
            end
        end else if (!found_reg) begin
            rsp.status = STS_UNKNOWN;
        end else begin
            sel_worker = hit_worker_reg;
            if (cad_req_code_t'(req_reg.req_type) == REQ_REMOVE) begin
                do_inval = 1'b1;
                do_dec   = 1'b1;
            end else begin
                rsp.routed_tag = req_reg.command_tag;
            end
        end
        sel_worker_wide = {4'b0000, sel_worker};
        rsp.worker      = sel_worker_wide[3:0];
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit_fire) begin
            m_data_reg <= rsp;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `CAD_ASSERT_NEXT(a_accept_starts_lookup, aclk, aresetn, in_fire, state_reg == ST_COMPARE,
                     "accepted transaction did not start a lookup")
    `CAD_ASSERT_SAME(a_single_binding, aclk, aresetn, state_reg == ST_COMMIT, $onehot0(hit_reg),
                     "channel bound in more than one slot")
    `CAD_ASSERT_SAME(a_one_slot_granted, aclk, aresetn, commit_fire && do_write,
                     $onehot(grant_reg), "new binding does not target exactly one slot")
    `CAD_ASSERT_NEXT(a_commit_presents, aclk, aresetn, commit_fire, m_valid,
                     "committed result not presented")

endmodule

>>> dv/cad_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the dispatcher, keeps its own copy of the binding
// table and the worker loads, and checks every result transaction in order.
module cad_checker #(
    parameter int MAX_WORKERS   = cad_pkg::MAX_WORKERS_DEF,
    parameter int CHANNEL_SLOTS = cad_pkg::CHANNEL_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cad_pkg::WCOUNT_W-1:0]  cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  cad_pkg::cad_req_t             s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  cad_pkg::cad_rsp_t             m_data,
    output int                            mismatch_count,
    output int                            rsp_outstanding
);
    import cad_pkg::*;

    logic [CHAN_ID_W-1:0] bind_id   [CHANNEL_SLOTS];
    bit                   bind_used [CHANNEL_SLOTS];
    int                   bind_wkr  [CHANNEL_SLOTS];
    int                   wkr_load  [MAX_WORKERS];
    int                   pool_size;
    cad_rsp_t             predicted_rsp_q [$];

    initial begin
        mismatch_count  = 0;
        rsp_outstanding = 0;
        pool_size       = 0;
    end

    function automatic void drop_bindings();
        for (int i = 0; i < CHANNEL_SLOTS; i++) begin
            bind_used[i] = 1'b0;
        end
        for (int w = 0; w < MAX_WORKERS; w++) begin
            wkr_load[w] = 0;
        end
    endfunction

    function automatic int lookup_binding(logic [CHAN_ID_W-1:0] id);
        int hit;
        hit = -1;
        for (int i = 0; i < CHANNEL_SLOTS; i++) begin
            if (hit < 0 && bind_used[i] && bind_id[i] == id) begin
                hit = i;
            end
        end
        return hit;
    endfunction

    // Applies one request to the table copy and returns the result it must give.
    function automatic cad_rsp_t predict_dispatch(cad_req_t req);
        cad_rsp_t      rsp;
        cad_req_code_t code;
        int            n;
        int            hit;
        int            slot;
        int            pick;
        rsp  = '0;
        code = cad_req_code_t'(req.req_type);
        n    = (pool_size > MAX_WORKERS) ? MAX_WORKERS : pool_size;
        hit  = lookup_binding(req.channel_id);
        if (code == REQ_UNUSED) begin
            rsp = '0;
        end else if (code == REQ_ROUTE && !req.command_present) begin
            rsp.status = STS_NOCMD;
        end else if (n == 0) begin
            rsp.status = STS_STOPPED;
        end else if (code == REQ_ADD) begin
            if (hit >= 0) begin
                rsp.worker = 4'(bind_wkr[hit]);
            end else begin
                slot = -1;
                for (int i = 0; i < CHANNEL_SLOTS; i++) begin
                    if (slot < 0 && !bind_used[i]) begin
                        slot = i;
                    end
                end
                if (slot < 0) begin
                    rsp.status = STS_FULL;
                end else begin
                    // Lowest index wins a tie on load.
                    pick = 0;
                    for (int w = 1; w < n; w++) begin
                        if (wkr_load[w] < wkr_load[pick]) begin
                            pick = w;
                        end
                    end
                    wkr_load[pick]++;
                    bind_used[slot] = 1'b1;
                    bind_id[slot]   = req.channel_id;
                    bind_wkr[slot]  = pick;
                    rsp.worker      = 4'(pick);
                end
            end
        end else if (hit < 0) begin
            rsp.status = STS_UNKNOWN;
        end else begin
            rsp.worker = 4'(bind_wkr[hit]);
            if (code == REQ_REMOVE) begin
                if (wkr_load[bind_wkr[hit]] > 0) begin
                    wkr_load[bind_wkr[hit]]--;
                end
                bind_used[hit] = 1'b0;
            end else begin
                rsp.routed_tag = req.command_tag;
            end
        end
        return rsp;
    endfunction

    always @(posedge aclk) begin : watch
        cad_rsp_t want;
        if (!aresetn) begin
            pool_size = 0;
            drop_bindings();
            predicted_rsp_q.delete();
        end else begin
            // Results are checked first: none can belong to a request taken at this edge.
            if (m_valid && m_ready) begin
                if (predicted_rsp_q.size() == 0) begin
                    $error("result transaction with no prediction waiting: status %0d",
                           m_data.status);
                    mismatch_count++;
                end else begin
                    want = predicted_rsp_q.pop_front();
                    if (m_data.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_data.status);
                        mismatch_count++;
                    end
                    if (m_data.worker !== want.worker) begin
                        $error("worker mismatch: expected %0d, actual %0d",
                               want.worker, m_data.worker);
                        mismatch_count++;
                    end
                    if (m_data.routed_tag !== want.routed_tag) begin
                        $error("routed_tag mismatch: expected 0x%08h, actual 0x%08h",
                               want.routed_tag, m_data.routed_tag);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                pool_size = int'(cfg_wr_data);
                drop_bindings();
            end
            if (s_valid && s_ready) begin
                predicted_rsp_q.push_back(predict_dispatch(s_data));
            end
        end
        rsp_outstanding = predicted_rsp_q.size();
    end

endmodule

>>> dv/channel_affinity_dispatcher_core_tb.sv
`timescale 1ns / 100ps

// Top of the dispatcher testbench. It only produces stimulus and gives the
// verdict; all prediction and comparison live in the checker instance.
module channel_affinity_dispatcher_core_tb;
    import cad_pkg::*;

    localparam int MAX_WORKERS   = MAX_WORKERS_DEF;
    localparam int CHANNEL_SLOTS = CHANNEL_SLOTS_DEF;
    // Channel ids are drawn from a pool a little larger than the table, so
    // that adds hit existing bindings often and the table can fill up.
    localparam int ID_POOL       = 80;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASES        = 8;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [WCOUNT_W-1:0] cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    cad_req_t            s_data      = '0;
    logic                m_ready     = 1'b0;
    logic                s_ready;
    logic                m_valid;
    cad_rsp_t            m_data;

    int mismatch_count;
    int rsp_outstanding;
    int quiet_cycles = 0;
    // While set, neither side inserts idle cycles.
    bit steady = 1'b0;

    logic [CHAN_ID_W-1:0] id_pool [ID_POOL];

    // Per phase of the random part: the worker count written first, the share
    // of add requests, how much of the id pool is in play, and the item count.
    // The first phase is nearly all adds over the whole pool so the table fills.
    int phase_wcount [PHASES] = '{16, 1, 31, 16, 0, 2, 9, 16};
    int phase_add    [PHASES] = '{97, 50, 60, 45, 50, 55, 50, 70};
    int phase_span   [PHASES] = '{80, 16, 40, 24, 16, 16, 48, 80};
    int phase_items  [PHASES] = '{130, 50, 70, 70, 30, 50, 60, 60};

    always #5 aclk = ~aclk;

    channel_affinity_dispatcher_core #(
        .MAX_WORKERS   (MAX_WORKERS),
        .CHANNEL_SLOTS (CHANNEL_SLOTS)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    cad_checker #(
        .MAX_WORKERS   (MAX_WORKERS),
        .CHANNEL_SLOTS (CHANNEL_SLOTS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .rsp_outstanding (rsp_outstanding)
    );

    // The result side stalls at random, with a chance of about 15 percent, except
    // while the steady stretch runs.
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 15);
    end

    // The watchdog counts cycles in which no transaction moves on either
    // channel. A correct block never goes quiet for long, since the slowest
    // request is an add that walks the whole row of worker loads.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic cad_req_t make_req(cad_req_code_t code, logic [CHAN_ID_W-1:0] id,
                                          logic [TAG_W-1:0] tag, logic present);
        cad_req_t req;
        req.req_type        = code;
        req.channel_id      = id;
        req.command_tag     = tag;
        req.command_present = present;
        return req;
    endfunction

    // Mostly requests on known ids with a command attached, plus some noise:
    // fresh random ids, routes without a command, and the unused code.
    function automatic cad_req_t random_req(int add_pct, int span);
        cad_req_t req;
        int       roll;
        roll = $urandom_range(99);
        if (roll < add_pct) begin
            req.req_type = REQ_ADD;
        end else if (roll >= 97) begin
            req.req_type = REQ_UNUSED;
        end else if ($urandom_range(1) == 1) begin
            req.req_type = REQ_ROUTE;
        end else begin
            req.req_type = REQ_REMOVE;
        end
        if ($urandom_range(9) == 0) begin
            req.channel_id = {$urandom, $urandom};
        end else begin
            req.channel_id = id_pool[$urandom_range(span - 1)];
        end
        req.command_tag     = $urandom;
        req.command_present = ($urandom_range(9) != 0);
        return req;
    endfunction

    // Presents one request transaction and returns right after the edge that
    // accepts it. Valid stays high afterwards; the next call either replaces
    // the payload or drops valid for an idle gap at the next falling edge.
    task automatic push_request(input cad_req_t req);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 15) begin
            gap = $urandom_range(4, 1);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stops sending and waits until every predicted result has been taken.
    // Every request yields a result, so the block is idle at that point.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (rsp_outstanding != 0) @(negedge aclk);
    endtask

    // A worker count write also wipes the table, so it only happens idle.
    task automatic write_worker_count(input int count);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= WCOUNT_W'(count);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < ID_POOL; i++) begin
            id_pool[i] = {$urandom, $urandom};
        end

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. Out of reset the pool is stopped: every request is
        // refused, except that a route without a command reports the missing
        // command first and the unused code answers plain ok.
        push_request(make_req(REQ_ADD, id_pool[0], '0, 1'b1));
        push_request(make_req(REQ_ROUTE, id_pool[0], 32'h1234_5678, 1'b0));
        push_request(make_req(REQ_ROUTE, id_pool[0], '1, 1'b1));
        push_request(make_req(REQ_REMOVE, id_pool[1], '0, 1'b0));
        push_request(make_req(REQ_UNUSED, '0, '0, 1'b0));

        // Three workers: first-time adds spread by load with ties to the lowest
        // index, a repeated add keeps its binding, a remove frees a worker that
        // the next add picks up again, and unknown ids are rejected.
        write_worker_count(3);
        push_request(make_req(REQ_ADD, id_pool[0], '0, 1'b0));
        push_request(make_req(REQ_ADD, id_pool[1], '1, 1'b1));
        push_request(make_req(REQ_ADD, id_pool[2], '0, 1'b0));
        push_request(make_req(REQ_ADD, id_pool[0], '0, 1'b1));
        push_request(make_req(REQ_ADD, id_pool[3], '0, 1'b0));
        push_request(make_req(REQ_REMOVE, id_pool[1], '0, 1'b0));
        push_request(make_req(REQ_REMOVE, id_pool[1], '0, 1'b1));
        push_request(make_req(REQ_ADD, id_pool[4], '0, 1'b0));
        push_request(make_req(REQ_ROUTE, id_pool[0], '1, 1'b1));
        push_request(make_req(REQ_ROUTE, id_pool[3], '0, 1'b1));
        push_request(make_req(REQ_ROUTE, id_pool[4], 32'hdead_beef, 1'b0));
        push_request(make_req(REQ_ROUTE, id_pool[9], 32'h0bad_f00d, 1'b1));
        push_request(make_req(REQ_UNUSED, '1, '1, 1'b1));

        // A count above the worker limit behaves as the full set of workers.
        write_worker_count(31);
        push_request(make_req(REQ_ADD, id_pool[5], '0, 1'b0));
        push_request(make_req(REQ_ADD, id_pool[6], '0, 1'b0));

        // Random part, one phase per worker count setting.
        for (int p = 0; p < PHASES; p++) begin
            write_worker_count(phase_wcount[p]);
            steady = (p == 3);
            for (int i = 0; i < phase_items[p]; i++) begin
                // Once mid-phase the sender holds off until the block is empty.
                if (p == 2 && i == 35) begin
                    wait_drained();
                end
                push_request(random_req(phase_add[p], phase_span[p]));
            end
        end
        steady = 1'b0;

        wait_drained();
        repeat (MAX_WORKERS + 8) @(negedge aclk);
        if (mismatch_count == 0 && rsp_outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/cad_pkg.sv
src/cad_slot_cell.sv
src/cad_load_cell.sv
src/channel_affinity_dispatcher_core.sv
dv/cad_checker.sv
dv/channel_affinity_dispatcher_core_tb.sv
